// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, constants and helpers of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    // Operand word size and the width of exact intermediates.
    localparam int WORD_BITS = 32;
    localparam int PROD_W    = 2 * WORD_BITS;
    localparam int CNT_W     = $clog2(PROD_W + 1);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_DIVZ    = 2'd2,
        ST_OVF     = 2'd3
    } t_status;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SEL_A,
        CMD_SEL_B,
        CMD_GCD_INIT,
        CMD_GCD_STEP,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_STORE_A,
        CMD_STORE_B,
        CMD_MUL_T1,
        CMD_MUL_T2,
        CMD_MUL_D,
        CMD_ADD,
        CMD_EMIT
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        t_status status;
    } t_cmd;

    // Flags returned by the datapath.
    typedef struct packed {
        logic zero_den;
        logic div_zero;
        logic gcd_done;
        logic div_done;
        logic overflow;
    } t_dp_status;

    // Sign and magnitude of one operand word.
    typedef struct packed {
        logic                 neg;
        logic [WORD_BITS-1:0] mag;
    } t_sm;

    // Takes the low WORD_BITS bits as two's complement and splits off the sign.
    function automatic t_sm to_sm(input logic [31:0] raw);
        t_sm                  r;
        logic [WORD_BITS-1:0] v;
        v     = raw[WORD_BITS-1:0];
        r.neg = v[WORD_BITS-1];
        r.mag = r.neg ? (~v + 1'b1) : v;
        return r;
    endfunction

endpackage

// ----- rtl/rau_dp.sv -----
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand registers, shared multiplier, binary GCD unit and a pair
// of restoring dividers that reduce a numerator and denominator together.
// ----------------------------------------------------------------------------
module rau_dp import rau_pkg::*; (
    input  logic             i_clk,
    input  t_cmd             i_cmd,
    input  logic [1:0]       i_req_type,
    input  logic [31:0]      i_a_num,
    input  logic [31:0]      i_a_den,
    input  logic [31:0]      i_b_num,
    input  logic [31:0]      i_b_den,
    output t_dp_status       o_flags,
    output logic [31:0]      o_res_num,
    output logic [30:0]      o_res_den,
    output logic [1:0]       o_status
);

    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (WORD_BITS - 1);

    t_op               r_op;
    logic              r_an_neg, r_bn_neg, r_wn_neg;
    logic [PROD_W-1:0] r_an, r_ad, r_bn, r_bd;
    logic [PROD_W-1:0] r_t1, r_t2;
    logic [PROD_W-1:0] r_wn, r_wd;
    logic [PROD_W-1:0] r_gu, r_gv, r_g;
    logic [CNT_W-1:0]  r_gk, r_dcnt;
    logic [PROD_W-1:0] r_rn, r_rd;
    logic [31:0]       r_res_num;
    logic [30:0]       r_res_den;
    logic [1:0]        r_res_st;

    t_sm s_an, s_ad, s_bn, s_bd;

    assign s_an = to_sm(i_a_num);
    assign s_ad = to_sm(i_a_den);
    assign s_bn = to_sm(i_b_num);
    assign s_bd = to_sm(i_b_den);

    // Shared multiplier with its operand selection.
    logic [WORD_BITS-1:0] w_mul_a, w_mul_b;
    logic [PROD_W-1:0]    w_prod;

    always_comb begin
        case (i_cmd.op)
            CMD_MUL_T1: begin
                w_mul_a = r_an[WORD_BITS-1:0];
                w_mul_b = (r_op == OP_MUL) ? r_bn[WORD_BITS-1:0] : r_bd[WORD_BITS-1:0];
            end
            CMD_MUL_T2: begin
                w_mul_a = r_bn[WORD_BITS-1:0];
                w_mul_b = r_ad[WORD_BITS-1:0];
            end
            default: begin
                w_mul_a = r_ad[WORD_BITS-1:0];
                w_mul_b = (r_op == OP_DIV) ? r_bn[WORD_BITS-1:0] : r_bd[WORD_BITS-1:0];
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Signed combination of the cross products.
    logic              w_sb_neg, w_sum_neg;
    logic [PROD_W-1:0] w_sum_mag;

    always_comb begin
        w_sb_neg = r_bn_neg ^ (r_op == OP_SUB);
        if (r_op == OP_ADD || r_op == OP_SUB) begin
            if (r_an_neg == w_sb_neg) begin
                w_sum_neg = r_an_neg;
                w_sum_mag = r_t1 + r_t2;
            end else if (r_t1 >= r_t2) begin
                w_sum_neg = r_an_neg;
                w_sum_mag = r_t1 - r_t2;
            end else begin
                w_sum_neg = w_sb_neg;
                w_sum_mag = r_t2 - r_t1;
            end
        end else begin
            w_sum_neg = r_an_neg ^ r_bn_neg;
            w_sum_mag = r_t1;
        end
        if (w_sum_mag == '0) begin
            w_sum_neg = 1'b0;
        end
    end

    // One restoring division step on numerator and denominator.
    logic [PROD_W:0] w_rn_sh, w_rd_sh, w_rn_nx, w_rd_nx;
    logic            w_rn_ge, w_rd_ge;

    always_comb begin
        w_rn_sh = {r_rn, r_wn[PROD_W-1]};
        w_rd_sh = {r_rd, r_wd[PROD_W-1]};
        w_rn_ge = w_rn_sh >= {1'b0, r_g};
        w_rd_ge = w_rd_sh >= {1'b0, r_g};
        w_rn_nx = w_rn_ge ? (w_rn_sh - {1'b0, r_g}) : w_rn_sh;
        w_rd_nx = w_rd_ge ? (w_rd_sh - {1'b0, r_g}) : w_rd_sh;
    end

    // Final result formatting.
    logic [31:0] w_num_mag, w_num32;

    assign w_num_mag = 32'(r_wn[WORD_BITS-1:0]);
    assign w_num32   = r_wn_neg ? (32'd0 - w_num_mag) : w_num_mag;

    // Register updates driven by the command.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_LOAD: begin
                r_op     <= t_op'(i_req_type);
                r_an     <= PROD_W'(s_an.mag);
                r_ad     <= PROD_W'(s_ad.mag);
                r_bn     <= PROD_W'(s_bn.mag);
                r_bd     <= PROD_W'(s_bd.mag);
                r_an_neg <= s_an.neg ^ (s_ad.neg && s_an.mag != '0);
                r_bn_neg <= s_bn.neg ^ (s_bd.neg && s_bn.mag != '0);
            end
            CMD_SEL_A: begin
                r_wn     <= r_an;
                r_wd     <= r_ad;
                r_wn_neg <= r_an_neg;
            end
            CMD_SEL_B: begin
                r_wn     <= r_bn;
                r_wd     <= r_bd;
                r_wn_neg <= r_bn_neg;
            end
            CMD_GCD_INIT: begin
                r_gu <= r_wn;
                r_gv <= r_wd;
                r_gk <= '0;
            end
            CMD_GCD_STEP: begin
                if (!r_gu[0] && !r_gv[0]) begin
                    r_gu <= r_gu >> 1;
                    r_gv <= r_gv >> 1;
                    r_gk <= r_gk + 1'b1;
                end else if (!r_gu[0]) begin
                    r_gu <= r_gu >> 1;
                end else if (!r_gv[0]) begin
                    r_gv <= r_gv >> 1;
                end else if (r_gu >= r_gv) begin
                    r_gu <= r_gu - r_gv;
                end else begin
                    r_gv <= r_gv - r_gu;
                end
            end
            CMD_DIV_INIT: begin
                r_g    <= (r_gu | r_gv) << r_gk;
                r_rn   <= '0;
                r_rd   <= '0;
                r_dcnt <= '0;
            end
            CMD_DIV_STEP: begin
                r_rn   <= w_rn_nx[PROD_W-1:0];
                r_rd   <= w_rd_nx[PROD_W-1:0];
                r_wn   <= {r_wn[PROD_W-2:0], w_rn_ge};
                r_wd   <= {r_wd[PROD_W-2:0], w_rd_ge};
                r_dcnt <= r_dcnt + 1'b1;
            end
            CMD_STORE_A: begin
                r_an     <= r_wn;
                r_ad     <= r_wd;
                r_an_neg <= r_wn_neg;
            end
            CMD_STORE_B: begin
                r_bn     <= r_wn;
                r_bd     <= r_wd;
                r_bn_neg <= r_wn_neg;
            end
            CMD_MUL_T1: begin
                r_t1 <= w_prod;
            end
            CMD_MUL_T2: begin
                r_t2 <= w_prod;
            end
            CMD_MUL_D: begin
                r_wd <= w_prod;
            end
            CMD_ADD: begin
                r_wn     <= w_sum_mag;
                r_wn_neg <= w_sum_neg;
            end
            CMD_EMIT: begin
                r_res_st <= i_cmd.status;
                if (i_cmd.status == ST_OK) begin
                    r_res_num <= w_num32;
                    r_res_den <= 31'(r_wd[WORD_BITS-1:0]);
                end else begin
                    r_res_num <= '0;
                    r_res_den <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Status flags for the controller.
    assign o_flags = '{
        zero_den: (r_ad == '0) || (r_bd == '0),
        div_zero: (r_op == OP_DIV) && (r_bn == '0),
        gcd_done: (r_gu == '0) || (r_gv == '0),
        div_done: (r_dcnt == CNT_W'(PROD_W)),
        overflow: (r_wd >= HALF) || (r_wn_neg ? (r_wn > HALF) : (r_wn >= HALF))
    };

    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_status  = r_res_st;

endmodule

// ----- rtl/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// rau_ctrl
// Controller: sequences load, operand reduction, cross products, result
// reduction and the hand-off of each result word to the output register.
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    input  t_dp_status i_flags,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_GINIT,
        S_GSTEP,
        S_DSTEP,
        S_DSTORE,
        S_SELB,
        S_DZCHK,
        S_MUL2,
        S_MUL3,
        S_ADD,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_R
    } t_phase;

    t_state  r_state, n_state;
    t_phase  r_phase, n_phase;
    t_status r_status, n_status;
    logic    r_out_valid, n_out_valid;

    // Next-state and command decode.
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_stall;
        o_cmd.op     = CMD_NONE;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = CMD_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_flags.zero_den) begin
                    n_status = ST_INVALID;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = CMD_SEL_A;
                    n_phase  = PH_A;
                    n_state  = S_GINIT;
                end
            end
            S_GINIT: begin
                o_cmd.op = CMD_GCD_INIT;
                n_state  = S_GSTEP;
            end
            S_GSTEP: begin
                if (i_flags.gcd_done) begin
                    o_cmd.op = CMD_DIV_INIT;
                    n_state  = S_DSTEP;
                end else begin
                    o_cmd.op = CMD_GCD_STEP;
                end
            end
            S_DSTEP: begin
                if (i_flags.div_done) begin
                    n_state = S_DSTORE;
                end else begin
                    o_cmd.op = CMD_DIV_STEP;
                end
            end
            S_DSTORE: begin
                case (r_phase)
                    PH_A: begin
                        o_cmd.op = CMD_STORE_A;
                        n_state  = S_SELB;
                    end
                    PH_B: begin
                        o_cmd.op = CMD_STORE_B;
                        n_state  = S_DZCHK;
                    end
                    default: begin
                        n_status = i_flags.overflow ? ST_OVF : ST_OK;
                        n_state  = S_DONE;
                    end
                endcase
            end
            S_SELB: begin
                o_cmd.op = CMD_SEL_B;
                n_phase  = PH_B;
                n_state  = S_GINIT;
            end
            S_DZCHK: begin
                if (i_flags.div_zero) begin
                    n_status = ST_DIVZ;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = CMD_MUL_T1;
                    n_state  = S_MUL2;
                end
            end
            S_MUL2: begin
                o_cmd.op = CMD_MUL_T2;
                n_state  = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.op = CMD_MUL_D;
                n_state  = S_ADD;
            end
            S_ADD: begin
                o_cmd.op = CMD_ADD;
                n_phase  = PH_R;
                n_state  = S_GINIT;
            end
            S_DONE: begin
                // The output register is free once its word has been taken.
                if (!r_out_valid || !i_stall) begin
                    o_cmd.op    = CMD_EMIT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_A;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // An accepted word always starts the operand check.
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_CHECK))
        else $error("accepted word did not enter the check state");

    // A written result is presented and the controller is free again.
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == CMD_EMIT) |=> (o_valid && r_state == S_IDLE))
        else $error("result write did not raise valid");

    // A pending stalled result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_stall) |-> (o_cmd.op != CMD_EMIT))
        else $error("pending result overwritten");

    // The GCD unit is not stepped once an operand has reached zero.
    a_gcd_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GSTEP && i_flags.gcd_done) |-> (o_cmd.op == CMD_DIV_INIT))
        else $error("gcd stepped past completion");

endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies or divides two fractions and returns the
// result reduced by the greatest common divisor, with a status code.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid / o_stall) takes one word: the operation code
// and two fractions. The output channel (o_valid / i_stall) returns one word:
// the reduced numerator, the positive denominator and a status code.
// Each word is worked on alone. The controller runs three reductions (first
// operand, second operand, result), each a binary GCD taking one step per
// cycle followed by a 64-step restoring divide. Loading and the
// zero-denominator check come first; the cross products come between the
// second operand reduction and the result reduction. A zero denominator is
// reported from the check state, before any reduction; division by a zero
// fraction is reported after the two operand reductions.
// o_stall is high from acceptance until the result is written to the output
// register. The next word may be accepted while that result waits; if the
// receiver still stalls when the next result is ready, the controller holds.
// Reset clears the controller and the output valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_a_num,
    input  logic [31:0] i_a_den,
    input  logic [31:0] i_b_num,
    input  logic [31:0] i_b_den,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_res_num,
    output logic [30:0] o_res_den,
    output logic [1:0]  o_status
);

    t_cmd       w_cmd;
    t_dp_status w_flags;

    // Sequencer.
    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_flags (w_flags),
        .o_cmd   (w_cmd)
    );

    // Arithmetic and result register.
    rau_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_req_type (i_req_type),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .o_flags    (w_flags),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_status   (o_status)
    );

endmodule

// ----- bench/rational_arithmetic_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// Self-checking bench for the rational arithmetic unit. A queue of request
// words feeds a clocked driver; a clocked monitor compares each result word
// with the fraction computed exactly by the bench, in order.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int  N_RANDOM    = 1600;
    localparam int  QUIET_TAIL  = 150;
    localparam longint CYCLE_LIMIT = 64'd6_000_000;

    typedef struct packed {
        t_op         op;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
    } t_req;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        t_status     status;
    } t_frac_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_req_type;
    logic [31:0] i_a_num;
    logic [31:0] i_a_den;
    logic [31:0] i_b_num;
    logic [31:0] i_b_den;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_res_num;
    logic [30:0] o_res_den;
    logic [1:0]  o_status;

    t_req        pending_reqs[$];
    t_frac_res   expected_fracs[$];
    int          mismatches;
    int          results_seen;
    int          words_sent;
    int          n_ovf, n_err;
    longint      cycle_count;
    bit          quiet_mode;
    bit          sender_pause;
    bit          long_hold;
    bit          stim_done;

    rational_arithmetic_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_status   (o_status)
    );

    // Clock with a 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Greatest common divisor of two exact magnitudes.
    function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
        while (x != 0 && y != 0) begin
            if (x > y) x = x % y;
            else y = y % x;
        end
        return x + y;
    endfunction

    // Exact fraction arithmetic on sign and 64-bit magnitude.
    function automatic t_frac_res solve_fraction(input t_req r);
        t_frac_res   res;
        logic [63:0] an, ad, bn, bd, g, t1, t2, rn, rd;
        bit          an_s, bn_s, t1_s, t2_s, rn_s;
        res = '0;
        an_s = r.a_num[31]; an = an_s ? 64'(-$signed({32'hffffffff, r.a_num})) : 64'(r.a_num);
        bn_s = r.b_num[31]; bn = bn_s ? 64'(-$signed({32'hffffffff, r.b_num})) : 64'(r.b_num);
        ad = r.a_den[31] ? 64'(-$signed({32'hffffffff, r.a_den})) : 64'(r.a_den);
        bd = r.b_den[31] ? 64'(-$signed({32'hffffffff, r.b_den})) : 64'(r.b_den);
        if (ad == 0 || bd == 0) begin
            res.status = ST_INVALID;
            return res;
        end
        an_s = (an != 0) && (an_s ^ r.a_den[31]);
        bn_s = (bn != 0) && (bn_s ^ r.b_den[31]);
        if (an == 0) ad = 1;
        else begin g = gcd64(an, ad); an = an / g; ad = ad / g; end
        if (bn == 0) bd = 1;
        else begin g = gcd64(bn, bd); bn = bn / g; bd = bd / g; end
        if (r.op == OP_DIV && bn == 0) begin
            res.status = ST_DIVZ;
            return res;
        end
        case (r.op)
            OP_ADD, OP_SUB: begin
                t1 = an * bd; t1_s = an_s && t1 != 0;
                t2 = bn * ad; t2_s = (bn_s ^ (r.op == OP_SUB)) && t2 != 0;
                if (t1_s == t2_s) begin rn = t1 + t2; rn_s = t1_s; end
                else if (t1 >= t2) begin rn = t1 - t2; rn_s = t1_s; end
                else begin rn = t2 - t1; rn_s = t2_s; end
                rd = ad * bd;
            end
            OP_MUL: begin rn = an * bn; rn_s = an_s ^ bn_s; rd = ad * bd; end
            default: begin rn = an * bd; rn_s = an_s ^ bn_s; rd = ad * bn; end
        endcase
        if (rn == 0) begin rn_s = 0; rd = 1; end
        else begin g = gcd64(rn, rd); rn = rn / g; rd = rd / g; end
        if (rd > 64'h7fffffff || (rn_s && rn > 64'h80000000) || (!rn_s && rn > 64'h7fffffff)) begin
            res.status = ST_OVF;
            return res;
        end
        res.num    = rn_s ? 32'(-rn) : rn[31:0];
        res.den    = rd[30:0];
        res.status = ST_OK;
        return res;
    endfunction

    // Operand values biased toward small numbers, extremes and zero.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'd0;
            3: return $urandom;
            4, 5: return 32'($signed($urandom_range(0, 40)) - 20);
            6: return 32'($signed($urandom_range(0, 2000)) - 1000);
            7: return {{16{1'b0}}, 16'($urandom)} * ($urandom_range(0, 1) ? 1 : -1);
            default: return 32'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    task automatic add_req(input t_op op, input logic [31:0] an, input logic [31:0] ad,
                           input logic [31:0] bn, input logic [31:0] bd);
        t_req r;
        r = '{op, an, ad, bn, bd};
        pending_reqs.push_back(r);
    endtask

    // Driver: offers queued words, with random gaps in bursts.
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                expected_fracs.push_back(solve_fraction('{t_op'(i_req_type), i_a_num,
                                         i_a_den, i_b_num, i_b_den}));
                words_sent <= words_sent + 1;
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (!quiet_mode && !long_hold && $urandom_range(0, 19) == 0) begin
                gap_left <= $urandom_range(1, 18) - 1;
                i_valid  <= 1'b0;
            end else if (pending_reqs.size() != 0 && !sender_pause) begin
                t_req r;
                r = pending_reqs.pop_front();
                i_valid    <= 1'b1;
                i_req_type <= r.op;
                i_a_num    <= r.a_num;
                i_a_den    <= r.a_den;
                i_b_num    <= r.b_num;
                i_b_den    <= r.b_den;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random bursts, plus one long hold-off.
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (long_hold) begin
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 18) - 1;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: compares each accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_fracs.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result word num=%h den=%h status=%0d",
                             o_res_num, o_res_den, o_status);
            end else begin
                t_frac_res e;
                e = expected_fracs.pop_front();
                results_seen <= results_seen + 1;
                if (e.status == ST_OVF) n_ovf <= n_ovf + 1;
                else if (e.status != ST_OK) n_err <= n_err + 1;
                if (o_res_num !== e.num || o_res_den !== e.den || o_status !== e.status) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected num=%h den=%h status=%0d, got num=%h den=%h status=%0d",
                                 e.num, e.den, e.status, o_res_num, o_res_den, o_status);
                end
            end
        end
    end

    // Cycle limit watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_op ops[4];
        ops = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};
        i_rst_n = 1'b0;
        i_valid = 1'b0; i_stall = 1'b0;
        i_req_type = '0; i_a_num = '0; i_a_den = '0; i_b_num = '0; i_b_den = '0;
        mismatches = 0; results_seen = 0; words_sent = 0; n_ovf = 0; n_err = 0;
        cycle_count = 0; quiet_mode = 0; sender_pause = 0; long_hold = 0; stim_done = 0;

        // Directed words: each operation, zero denominators, zero divisor,
        // extremes and overflow.
        foreach (ops[k]) add_req(ops[k], 32'd1, 32'd2, 32'd1, 32'd3);
        add_req(OP_ADD, 32'd5, 32'd0, 32'd1, 32'd3);
        add_req(OP_DIV, 32'd5, 32'd7, 32'd1, 32'd0);
        add_req(OP_DIV, 32'd5, 32'd7, 32'd0, 32'd9);
        add_req(OP_DIV, 32'd0, 32'd0, 32'd0, 32'd9);
        add_req(OP_SUB, 32'd3, 32'd4, 32'd3, 32'd4);
        add_req(OP_MUL, 32'h80000000, 32'd1, 32'hffffffff, 32'd1);
        add_req(OP_MUL, 32'h80000000, 32'd1, 32'd1, 32'd1);
        add_req(OP_DIV, 32'd1, 32'h80000000, 32'd1, 32'd1);
        add_req(OP_ADD, 32'h7fffffff, 32'd1, 32'd1, 32'd1);
        add_req(OP_ADD, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'hffffffff);
        add_req(OP_MUL, 32'd6, 32'hfffffff7, 32'hfffffffd, 32'd4);
        add_req(OP_SUB, 32'h80000000, 32'd1, 32'h7fffffff, 32'd1);
        add_req(OP_DIV, 32'h7fffffff, 32'h7ffffffe, 32'h7ffffffd, 32'h7fffffff);
        add_req(OP_ADD, 32'd1, 32'h7fffffff, 32'd1, 32'h7ffffffe);
        add_req(OP_MUL, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_RANDOM; i++) begin
            logic [31:0] an, ad, bn, bd;
            an = pick_word(); ad = pick_word(); bn = pick_word(); bd = pick_word();
            // Keep most denominators nonzero so the arithmetic gets exercised.
            if (ad == 0 && $urandom_range(0, 3) != 0) ad = 1;
            if (bd == 0 && $urandom_range(0, 3) != 0) bd = 32'hffffffff;
            add_req(t_op'($urandom_range(0, 3)), an, ad, bn, bd);

            // Sender pauses until all results are back.
            if (i == 300) begin
                wait (pending_reqs.size() == 0);
                sender_pause = 1;
                wait (expected_fracs.size() == 0 && !i_valid);
                sender_pause = 0;
            end
            // Receiver holds off a long time while words keep coming.
            if (i == 700) begin
                @(posedge i_clk);
                long_hold <= 1'b1;
                repeat (3000) @(posedge i_clk);
                long_hold <= 1'b0;
            end
            if (i == N_RANDOM - QUIET_TAIL) begin
                wait (pending_reqs.size() < 20);
                quiet_mode = 1;
            end
        end

        wait (pending_reqs.size() == 0 && !i_valid);
        wait (expected_fracs.size() == 0);
        repeat (700) @(posedge i_clk);

        $display("ran %0d request words through all four operations; %0d results checked,",
                 words_sent, results_seen);
        $display("%0d error-status results and %0d overflow results among them", n_err, n_ovf);
        if (mismatches == 0 && expected_fracs.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
